/* rtl/rmd256_pkg.sv */
// shared types, constants and step tables for the ripemd-256 compression block
package rmd256_pkg;

	localparam int WordW = 32;
	localparam int Steps = 64;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_FETCH,
		ST_ROUND,
		ST_FOLD,
		ST_EMIT
	} ctrl_state_t;

	// controller to datapath commands
	typedef struct packed {
		logic       load_word;
		logic       init_chain;
		logic       begin_rounds;
		logic       fetch;
		logic       step;
		logic [5:0] step_idx;
		logic       fold;
		logic       out_load;
	} dp_cmd_t;

	localparam logic [WordW-1:0] INIT_CV [8] = '{
		32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476,
		32'h76543210, 32'hFEDCBA98, 32'h89ABCDEF, 32'h01234567};

	localparam logic [WordW-1:0] K_LEFT  [4] = '{32'h00000000, 32'h5A827999,
		32'h6ED9EBA1, 32'h8F1BBCDC};
	localparam logic [WordW-1:0] K_RIGHT [4] = '{32'h50A28BE6, 32'h5C4DD124,
		32'h6D703EF3, 32'h00000000};

	localparam logic [3:0] R_LEFT [64] = '{
		0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12, 13, 14, 15,
		7, 4, 13, 1, 10, 6, 15, 3, 12, 0, 9, 5, 2, 14, 11, 8,
		3, 10, 14, 4, 9, 15, 8, 1, 2, 7, 0, 6, 13, 11, 5, 12,
		1, 9, 11, 10, 0, 8, 12, 4, 13, 3, 7, 15, 14, 5, 6, 2};
	localparam logic [3:0] R_RIGHT [64] = '{
		5, 14, 7, 0, 9, 2, 11, 4, 13, 6, 15, 8, 1, 10, 3, 12,
		6, 11, 3, 7, 0, 13, 5, 10, 14, 15, 8, 12, 4, 9, 1, 2,
		15, 5, 1, 3, 7, 14, 6, 9, 11, 8, 12, 2, 10, 0, 4, 13,
		8, 6, 4, 1, 3, 11, 15, 0, 5, 12, 2, 13, 9, 7, 10, 14};
	localparam logic [4:0] S_LEFT [64] = '{
		11, 14, 15, 12, 5, 8, 7, 9, 11, 13, 14, 15, 6, 7, 9, 8,
		7, 6, 8, 13, 11, 9, 7, 15, 7, 12, 15, 9, 11, 7, 13, 12,
		11, 13, 6, 7, 14, 9, 13, 15, 14, 8, 13, 6, 5, 12, 7, 5,
		11, 12, 14, 15, 14, 15, 9, 8, 9, 14, 5, 6, 8, 6, 5, 12};
	localparam logic [4:0] S_RIGHT [64] = '{
		8, 9, 9, 11, 13, 15, 15, 5, 7, 7, 8, 11, 14, 14, 12, 6,
		9, 13, 15, 7, 12, 8, 9, 11, 7, 7, 12, 7, 6, 15, 13, 11,
		9, 7, 15, 11, 8, 6, 6, 14, 12, 13, 5, 14, 13, 13, 7, 5,
		15, 5, 8, 11, 14, 14, 6, 14, 6, 9, 12, 9, 12, 5, 15, 8};

	function automatic logic [WordW-1:0] bool_f(input logic [1:0] f,
		input logic [WordW-1:0] x, input logic [WordW-1:0] y,
		input logic [WordW-1:0] z);
		logic [WordW-1:0] r;
		case (f)
			2'd0:    r = x ^ y ^ z;
			2'd1:    r = (x & y) | (~x & z);
			2'd2:    r = (x | ~y) ^ z;
			default: r = (x & z) | (y & ~z);
		endcase
		return r;
	endfunction

	function automatic logic [WordW-1:0] rotl(input logic [WordW-1:0] v,
		input logic [4:0] n);
		logic [2*WordW-1:0] d;
		d = {v, v} << n;
		return d[2*WordW-1:WordW];
	endfunction

endpackage

/* rtl/rmd256_ram.sv */
// generic single-port write, single read port ram with registered read
module rmd256_ram #(
	parameter int Width = 32,
	parameter int Depth = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);

	logic [Width-1:0] mem_q [Depth];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* rtl/rmd256_ctrl.sv */
// controller state machine: word loading, round sequencing, digest emission
module rmd256_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_start,
	input  logic                in_end,
	output logic                in_ready,
	input  logic                out_free,
	input  logic                out_taken,
	output rmd256_pkg::dp_cmd_t cmd,
	output logic [3:0]          word_cnt
);
	import rmd256_pkg::*;

	ctrl_state_t state_q, state_d;
	logic [3:0]  cnt_q;
	logic [5:0]  step_q;
	logic        end_q;
	logic [2:0]  emit_q;
	logic        acc;

	assign word_cnt = cnt_q;
	assign in_ready = (state_q == ST_LOAD);
	assign acc      = in_valid && in_ready;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_LOAD:  if (acc && cnt_q == 4'd15) state_d = ST_FETCH;
			ST_FETCH: state_d = ST_ROUND;
			ST_ROUND: if (step_q == 6'd63) state_d = ST_FOLD;
			ST_FOLD:  state_d = end_q ? ST_EMIT : ST_LOAD;
			ST_EMIT:  if (out_taken && emit_q == 3'd7) state_d = ST_LOAD;
			default:  state_d = ST_LOAD;
		endcase
	end

	// outputs
	always_comb begin
		cmd          = '0;
		cmd.step_idx = step_q;
		unique case (state_q)
			ST_LOAD: begin
				cmd.load_word  = acc;
				cmd.init_chain = acc && in_start && cnt_q == 4'd0;
			end
			ST_FETCH: begin
				cmd.fetch        = 1'b1;
				cmd.begin_rounds = 1'b1;
			end
			ST_ROUND: begin
				cmd.step  = 1'b1;
				cmd.fetch = 1'b1;
			end
			ST_FOLD: cmd.fold = 1'b1;
			ST_EMIT: cmd.out_load = out_free || out_taken;
			default: cmd = '0;
		endcase
	end

	// counters and state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			cnt_q   <= '0;
			step_q  <= '0;
			end_q   <= 1'b0;
			emit_q  <= '0;
		end else begin
			state_q <= state_d;
			if (acc) begin
				cnt_q <= cnt_q + 4'd1;
				end_q <= in_end;
			end
			if (state_q == ST_ROUND) step_q <= step_q + 6'd1;
			if (cmd.out_load) emit_q <= emit_q + 3'd1;
		end
	end

	// ready only while loading
	a_ready_load: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> state_q == ST_LOAD) else $error("ready outside load");
	// rounds start with step zero
	a_step_zero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FETCH |-> step_q == 6'd0) else $error("step not zero");
	// word count wraps before rounds
	a_cnt_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FOLD |-> cnt_q == 4'd0) else $error("word count off");

endmodule

/* rtl/rmd256_dp.sv */
// datapath: block word store, two line registers, chaining words, output register
module rmd256_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  rmd256_pkg::dp_cmd_t cmd,
	input  logic [3:0]          word_cnt,
	input  logic [31:0]         in_word,
	input  logic                out_ready,
	output logic                out_valid,
	output logic [31:0]         out_word,
	output logic [2:0]          out_index,
	output logic                out_last,
	output logic                out_free,
	output logic                out_taken
);
	import rmd256_pkg::*;

	logic [WordW-1:0] cv_q [8];
	logic [WordW-1:0] l_q [4];
	logic [WordW-1:0] r_q [4];
	logic [WordW-1:0] nl [4];
	logic [WordW-1:0] nr [4];
	logic [WordW-1:0] swap;
	logic [WordW-1:0] xl, xr, tl, tr;
	logic [5:0]       fetch_idx;
	logic [1:0]       rnd;
	logic [3:0]       ra_l, ra_r;
	logic [2:0]       oidx_q;
	logic             vld_q;

	// two ram copies give one word per line per step
	assign fetch_idx = cmd.step ? cmd.step_idx + 6'd1 : 6'd0;
	assign ra_l = R_LEFT[fetch_idx];
	assign ra_r = R_RIGHT[fetch_idx];

	rmd256_ram #(.Width(WordW), .Depth(16)) u_ram_l (
		.clk(clk), .we(cmd.load_word), .waddr(word_cnt), .wdata(in_word),
		.raddr(ra_l), .rdata(xl));
	rmd256_ram #(.Width(WordW), .Depth(16)) u_ram_r (
		.clk(clk), .we(cmd.load_word), .waddr(word_cnt), .wdata(in_word),
		.raddr(ra_r), .rdata(xr));

	assign rnd = cmd.step_idx[5:4];

	// one step on each line
	assign tl = rotl(l_q[0] + bool_f(rnd, l_q[1], l_q[2], l_q[3]) + xl
		+ K_LEFT[rnd], S_LEFT[cmd.step_idx]);
	assign tr = rotl(r_q[0] + bool_f(2'd3 - rnd, r_q[1], r_q[2], r_q[3]) + xr
		+ K_RIGHT[rnd], S_RIGHT[cmd.step_idx]);

	// next line words, with the exchange after the last step of a round
	always_comb begin
		nl   = '{l_q[3], tl, l_q[1], l_q[2]};
		nr   = '{r_q[3], tr, r_q[1], r_q[2]};
		swap = nl[rnd];
		if (cmd.step_idx[3:0] == 4'd15) begin
			nl[rnd] = nr[rnd];
			nr[rnd] = swap;
		end
	end

	// working lines
	always_ff @(posedge clk) begin
		if (cmd.begin_rounds) begin
			for (int i = 0; i < 4; i++) begin
				l_q[i] <= cv_q[i];
				r_q[i] <= cv_q[i+4];
			end
		end else if (cmd.step) begin
			l_q <= nl;
			r_q <= nr;
		end
	end

	// chaining words
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cv_q <= INIT_CV;
		end else if (cmd.init_chain) begin
			cv_q <= INIT_CV;
		end else if (cmd.fold) begin
			for (int i = 0; i < 4; i++) begin
				cv_q[i]   <= cv_q[i] + l_q[i];
				cv_q[i+4] <= cv_q[i+4] + r_q[i];
			end
		end
	end

	// output register
	assign out_free  = !vld_q;
	assign out_taken = vld_q && out_ready;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= 1'b0;
			oidx_q <= '0;
		end else if (cmd.out_load) begin
			vld_q  <= 1'b1;
			oidx_q <= oidx_q + 3'd1;
		end else if (out_taken) begin
			vld_q <= 1'b0;
		end
	end
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_word  <= cv_q[oidx_q];
			out_index <= oidx_q;
			out_last  <= oidx_q == 3'd7;
		end
	end
	assign out_valid = vld_q;

	// output never loaded over a waiting word
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!vld_q || out_ready)) else $error("output overrun");
	// fold never overlaps a step
	a_fold_alone: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.fold && cmd.step)) else $error("fold during step");
	// chain reload only during word loading
	a_init_load: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.init_chain |-> cmd.load_word) else $error("stray reload");

endmodule

/* rtl/ripemd256_compress_top.sv */
// top level of the ripemd-256 compression block
//  channel | dir | handshake                | payload
//  s_axis  | in  | s_axis_tvalid/tready     | tdata message_word, tuser start/end
//  m_axis  | out | m_axis_tvalid/tready     | tdata digest_word/index, tlast
// words 1..15 of a block are taken while loading; the 16th is followed by
// a busy phase (fetch, 64 steps with one step per line, fold).
// a digest adds eight output transactions, one per cycle without stall.
// reset is asynchronous, active low; chaining words return to their initial values.
// output stalls hold the emission; input is taken only while loading words.
module ripemd256_compress_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // message_word
	input  logic [1:0]  s_axis_tuser,  // start_message, end_message
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,  // digest_word, digest_index, 5 zero bits
	output logic        m_axis_tlast   // digest_last
);
	import rmd256_pkg::*;

	dp_cmd_t     cmd;
	logic [3:0]  word_cnt;
	logic        out_free, out_taken;
	logic [31:0] dw;
	logic [2:0]  di;

	rmd256_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(s_axis_tvalid),
		.in_start(s_axis_tuser[0]), .in_end(s_axis_tuser[1]),
		.in_ready(s_axis_tready), .out_free(out_free), .out_taken(out_taken),
		.cmd(cmd), .word_cnt(word_cnt));

	rmd256_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .word_cnt(word_cnt),
		.in_word(s_axis_tdata), .out_ready(m_axis_tready),
		.out_valid(m_axis_tvalid), .out_word(dw), .out_index(di),
		.out_last(m_axis_tlast), .out_free(out_free), .out_taken(out_taken));

	assign m_axis_tdata = {5'd0, di, dw};

endmodule

/* bench/tb_top.sv */
// self-checking testbench for the ripemd-256 compression block
`timescale 1ns / 1ps

module tb_top;
	import rmd256_pkg::*;

	localparam logic [31:0] IV [8] = '{
		32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476,
		32'h76543210, 32'hFEDCBA98, 32'h89ABCDEF, 32'h01234567};
	localparam logic [31:0] KL [4] = '{32'h00000000, 32'h5A827999, 32'h6ED9EBA1, 32'h8F1BBCDC};
	localparam logic [31:0] KR [4] = '{32'h50A28BE6, 32'h5C4DD124, 32'h6D703EF3, 32'h00000000};
	localparam int LIMIT = 400000;

	typedef struct packed {
		logic [31:0] word;
		logic [2:0]  index;
		logic        last;
	} digest_t;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        s_axis_tvalid = 0;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata = '0;
	logic [1:0]  s_axis_tuser = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 0;
	logic [39:0] m_axis_tdata;
	logic        m_axis_tlast;

	// predictor state
	logic [31:0] chain [8];
	logic [31:0] blk [16];
	int          word_pos;
	digest_t     digest_q [$];

	int errors = 0;
	int words_sent = 0;
	int digests_seen = 0;
	int cycles = 0;
	int hold_cycles = 0;

	ripemd256_compress_top DUT (.*);

	// clock
	always begin
		#2 clk = 1;
		#2 clk = 0;
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("FAIL ripemd256_compress_top");
			$finish;
		end
	end

	function automatic logic [31:0] rol32(logic [31:0] v, int n);
		return (n == 0) ? v : ((v << n) | (v >> (32 - n)));
	endfunction

	function automatic logic [31:0] mix(int f, logic [31:0] x, y, z);
		case (f)
			0: return x ^ y ^ z;
			1: return (x & y) | (~x & z);
			2: return (x | ~y) ^ z;
			default: return (x & z) | (y & ~z);
		endcase
	endfunction

	// two-line compression of the buffered block into the chaining words
	task automatic compress_block();
		logic [31:0] l [4];
		logic [31:0] r [4];
		logic [31:0] t;
		int j;
		for (int i = 0; i < 4; i++) begin
			l[i] = chain[i];
			r[i] = chain[i + 4];
		end
		for (int rnd = 0; rnd < 4; rnd++) begin
			for (int k = 0; k < 16; k++) begin
				j = rnd * 16 + k;
				t = rol32(l[0] + mix(rnd, l[1], l[2], l[3]) + blk[R_LEFT[j]] + KL[rnd],
					S_LEFT[j]);
				l[0] = l[3]; l[3] = l[2]; l[2] = l[1]; l[1] = t;
				t = rol32(r[0] + mix(3 - rnd, r[1], r[2], r[3]) + blk[R_RIGHT[j]] + KR[rnd],
					S_RIGHT[j]);
				r[0] = r[3]; r[3] = r[2]; r[2] = r[1]; r[1] = t;
			end
			t = l[rnd]; l[rnd] = r[rnd]; r[rnd] = t;
		end
		for (int i = 0; i < 4; i++) begin
			chain[i] += l[i];
			chain[i + 4] += r[i];
		end
	endtask

	// update the predictor with one accepted word
	task automatic predict_word(logic [31:0] w, logic st, logic en);
		digest_t d;
		if (word_pos == 0 && st)
			chain = IV;
		blk[word_pos] = w;
		if (word_pos == 15) begin
			compress_block();
			if (en) begin
				for (int i = 0; i < 8; i++) begin
					d.word = chain[i];
					d.index = i[2:0];
					d.last = (i == 7);
					digest_q.push_back(d);
				end
			end
		end
		word_pos = (word_pos + 1) % 16;
	endtask

	// send one word, after a random gap
	task automatic send_word(logic [31:0] w, logic st, logic en);
		int gap;
		gap = $urandom_range(0, 6);
		if (gap > 0) begin
			s_axis_tvalid <= 0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1;
		s_axis_tdata <= w;
		s_axis_tuser <= {en, st};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		predict_word(w, st, en);
		words_sent++;
		@(negedge clk);
	endtask

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		errors++;
		$display("mismatch %s: got %h expected %h", what, got, want);
	endtask

	// receiver: random wait before each transaction, plus one long hold-off
	initial begin
		int gap;
		int seen;
		gap = $urandom_range(0, 6);
		seen = 0;
		forever begin
			@(negedge clk);
			if (digests_seen != seen) begin
				seen = digests_seen;
				gap = $urandom_range(0, 6);
			end
			if (hold_cycles > 0) begin
				m_axis_tready <= 0;
				hold_cycles--;
			end else if (gap > 0) begin
				m_axis_tready <= 0;
				gap--;
			end else
				m_axis_tready <= 1;
		end
	end

	// digest checker
	always @(posedge clk) begin
		digest_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			digests_seen++;
			if (digest_q.size() == 0) begin
				errors++;
				$display("unexpected digest transaction %h", m_axis_tdata);
			end else begin
				want = digest_q.pop_front();
				if (m_axis_tdata[31:0] !== want.word)
					report("digest_word", m_axis_tdata[31:0], want.word);
				if (m_axis_tdata[34:32] !== want.index)
					report("digest_index", 32'(m_axis_tdata[34:32]), 32'(want.index));
				if (m_axis_tdata[39:35] !== 5'b0)
					report("pad bits", 32'(m_axis_tdata[39:35]), 32'd0);
				if (m_axis_tlast !== want.last)
					report("digest_last", 32'(m_axis_tlast), 32'(want.last));
			end
		end
	end

	task automatic send_block(int kind, logic st, logic en);
		logic [31:0] w;
		for (int i = 0; i < 16; i++) begin
			case (kind)
				0: w = '0;
				1: w = '1;
				default: w = $urandom;
			endcase
			send_word(w, (i == 0) ? st : 1'($urandom_range(0, 1)),
				(i == 15) ? en : 1'($urandom_range(0, 1)));
		end
	endtask

	task automatic wait_drain();
		s_axis_tvalid <= 0;
		while (digest_q.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	// extremes: all-zero and all-one blocks, single-block digests
	task automatic test_extremes();
		send_block(0, 1, 1);
		send_block(1, 1, 1);
	endtask

	// chaining: no start flag continues after a digest, over two blocks
	task automatic test_chaining();
		send_block(2, 0, 0);
		send_block(2, 0, 1);
	endtask

	// long receiver hold-off while the sender keeps going, then a drained pause
	task automatic test_backpressure();
		hold_cycles = 600;
		send_block(2, 1, 1);
		send_block(2, 1, 1);
		wait_drain();
	endtask

	// one random block with a random start flag
	task automatic test_random();
		send_block(2, 1'($urandom_range(0, 1)), 1'b1);
	endtask

	initial begin
		chain = IV;
		word_pos = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		test_extremes();
		test_chaining();
		test_backpressure();
		test_random();
		wait_drain();
		repeat (100) @(posedge clk);
		$display("sent %0d message words, checked %0d digest words", words_sent,
			digests_seen);
		if (errors == 0 && digest_q.size() == 0)
			$display("PASS ripemd256_compress_top");
		else
			$display("FAIL ripemd256_compress_top");
		$finish;
	end

endmodule
